// File: rtl/core/qvr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_pkg
// Widths, payload types and rounding constants shared by the quaternion
// vector rotation pipeline.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int QuatWidth    = 16;
  localparam int QuatFracBits = 14;
  localparam int VecWidth     = 16;

  // q component products, matrix entries, matrix-vector terms, row sums
  localparam int ProdWidth  = 2 * QuatWidth;
  localparam int MatWidth   = ProdWidth + 2;
  localparam int TermWidth  = MatWidth + VecWidth;
  localparam int SumWidth   = TermWidth + 2;
  localparam int RoundShift = 2 * QuatFracBits;
  localparam int RowWidth   = SumWidth - RoundShift;

  localparam logic [SumWidth-1:0] RoundHalf = SumWidth'(1) << (RoundShift - 1);

  typedef struct packed {
    logic [QuatWidth-1:0] x;
    logic [QuatWidth-1:0] y;
    logic [QuatWidth-1:0] z;
    logic [QuatWidth-1:0] w;
  } quat_t;

  // element 0 is x, 1 is y, 2 is z
  typedef logic [2:0][VecWidth-1:0] vec_t;

  typedef struct packed {
    logic [ProdWidth-1:0] xx;
    logic [ProdWidth-1:0] yy;
    logic [ProdWidth-1:0] zz;
    logic [ProdWidth-1:0] ww;
    logic [ProdWidth-1:0] xy;
    logic [ProdWidth-1:0] xz;
    logic [ProdWidth-1:0] yz;
    logic [ProdWidth-1:0] wx;
    logic [ProdWidth-1:0] wy;
    logic [ProdWidth-1:0] wz;
  } prod_t;

  // [row][col]
  typedef logic [2:0][2:0][MatWidth-1:0]  mat_t;
  typedef logic [2:0][2:0][TermWidth-1:0] term_t;

endpackage

// File: rtl/core/qvr_prod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_prod
// Stage 1: all pairwise products of the quaternion components.
// ----------------------------------------------------------------------------
module qvr_prod (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          stall_o,
  input  qvr_pkg::quat_t quat_i,
  input  qvr_pkg::vec_t  vec_i,
  output logic          valid_o,
  input  logic          stall_i,
  output qvr_pkg::prod_t prod_o,
  output qvr_pkg::vec_t  vec_o
);

  localparam int QW = qvr_pkg::QuatWidth;
  localparam int PW = qvr_pkg::ProdWidth;

  logic           valid_q;
  qvr_pkg::prod_t prod_d, prod_q;
  qvr_pkg::vec_t  vec_q;

  logic [PW-1:0] x, y, z, w;

  assign stall_o = valid_q & stall_i;

  assign x = {{(PW-QW){quat_i.x[QW-1]}}, quat_i.x};
  assign y = {{(PW-QW){quat_i.y[QW-1]}}, quat_i.y};
  assign z = {{(PW-QW){quat_i.z[QW-1]}}, quat_i.z};
  assign w = {{(PW-QW){quat_i.w[QW-1]}}, quat_i.w};

  always_comb begin
    prod_d.xx = $signed(x) * $signed(x);
    prod_d.yy = $signed(y) * $signed(y);
    prod_d.zz = $signed(z) * $signed(z);
    prod_d.ww = $signed(w) * $signed(w);
    prod_d.xy = $signed(x) * $signed(y);
    prod_d.xz = $signed(x) * $signed(z);
    prod_d.yz = $signed(y) * $signed(z);
    prod_d.wx = $signed(w) * $signed(x);
    prod_d.wy = $signed(w) * $signed(y);
    prod_d.wz = $signed(w) * $signed(z);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o) begin
      prod_q <= prod_d;
      vec_q  <= vec_i;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;
  assign vec_o   = vec_q;

endmodule

// File: rtl/core/qvr_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_matrix
// Stage 2: the rotation matrix of q (scaled by |q|^2) from the products.
// ----------------------------------------------------------------------------
module qvr_matrix (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           stall_o,
  input  qvr_pkg::prod_t prod_i,
  input  qvr_pkg::vec_t  vec_i,
  output logic           valid_o,
  input  logic           stall_i,
  output qvr_pkg::mat_t  mat_o,
  output qvr_pkg::vec_t  vec_o
);

  localparam int PW = qvr_pkg::ProdWidth;
  localparam int MW = qvr_pkg::MatWidth;

  logic          valid_q;
  qvr_pkg::mat_t mat_d, mat_q;
  qvr_pkg::vec_t vec_q;

  logic [MW-1:0] xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;

  assign stall_o = valid_q & stall_i;

  assign xx = {{(MW-PW){prod_i.xx[PW-1]}}, prod_i.xx};
  assign yy = {{(MW-PW){prod_i.yy[PW-1]}}, prod_i.yy};
  assign zz = {{(MW-PW){prod_i.zz[PW-1]}}, prod_i.zz};
  assign ww = {{(MW-PW){prod_i.ww[PW-1]}}, prod_i.ww};
  assign xy = {{(MW-PW){prod_i.xy[PW-1]}}, prod_i.xy};
  assign xz = {{(MW-PW){prod_i.xz[PW-1]}}, prod_i.xz};
  assign yz = {{(MW-PW){prod_i.yz[PW-1]}}, prod_i.yz};
  assign wx = {{(MW-PW){prod_i.wx[PW-1]}}, prod_i.wx};
  assign wy = {{(MW-PW){prod_i.wy[PW-1]}}, prod_i.wy};
  assign wz = {{(MW-PW){prod_i.wz[PW-1]}}, prod_i.wz};

  always_comb begin
    mat_d[0][0] = ww + xx - yy - zz;
    mat_d[0][1] = (xy - wz) << 1;
    mat_d[0][2] = (xz + wy) << 1;
    mat_d[1][0] = (xy + wz) << 1;
    mat_d[1][1] = ww - xx + yy - zz;
    mat_d[1][2] = (yz - wx) << 1;
    mat_d[2][0] = (xz - wy) << 1;
    mat_d[2][1] = (yz + wx) << 1;
    mat_d[2][2] = ww - xx - yy + zz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o) begin
      mat_q <= mat_d;
      vec_q <= vec_i;
    end
  end

  assign valid_o = valid_q;
  assign mat_o   = mat_q;
  assign vec_o   = vec_q;

endmodule

// File: rtl/core/qvr_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_mul
// Stage 3: one multiplier per matrix entry, entry times vector element.
// ----------------------------------------------------------------------------
module qvr_mul (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           stall_o,
  input  qvr_pkg::mat_t  mat_i,
  input  qvr_pkg::vec_t  vec_i,
  output logic           valid_o,
  input  logic           stall_i,
  output qvr_pkg::term_t term_o
);

  localparam int MW = qvr_pkg::MatWidth;
  localparam int VW = qvr_pkg::VecWidth;
  localparam int TW = qvr_pkg::TermWidth;

  logic           valid_q;
  qvr_pkg::term_t term_d, term_q;

  assign stall_o = valid_q & stall_i;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        term_d[r][c] = $signed({{(TW-MW){mat_i[r][c][MW-1]}}, mat_i[r][c]})
                     * $signed({{(TW-VW){vec_i[c][VW-1]}}, vec_i[c]});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o) begin
      term_q <= term_d;
    end
  end

  assign valid_o = valid_q;
  assign term_o  = term_q;

endmodule

// File: rtl/core/qvr_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_round
// Stage 4: row sums, round half up, clamp to the vector range; output
// register.
// ----------------------------------------------------------------------------
module qvr_round (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           stall_o,
  input  qvr_pkg::term_t term_i,
  output logic           valid_o,
  input  logic           stall_i,
  output qvr_pkg::vec_t  rot_o,
  output logic           clamped_o
);

  localparam int TW = qvr_pkg::TermWidth;
  localparam int SW = qvr_pkg::SumWidth;
  localparam int RW = qvr_pkg::RowWidth;
  localparam int VW = qvr_pkg::VecWidth;

  logic          valid_q;
  qvr_pkg::vec_t rot_d, rot_q;
  logic          clamped_d, clamped_q;

  logic [2:0][SW-1:0] sum;
  logic [2:0][RW-1:0] row;
  logic [2:0]         over;

  assign stall_o = valid_q & stall_i;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = {{(SW-TW){term_i[r][0][TW-1]}}, term_i[r][0]}
             + {{(SW-TW){term_i[r][1][TW-1]}}, term_i[r][1]}
             + {{(SW-TW){term_i[r][2][TW-1]}}, term_i[r][2]}
             + qvr_pkg::RoundHalf;
      row[r]  = sum[r][SW-1:qvr_pkg::RoundShift];
      over[r] = !((&row[r][RW-1:VW-1]) || !(|row[r][RW-1:VW-1]));
      if (over[r]) begin
        rot_d[r] = {row[r][RW-1], {(VW-1){~row[r][RW-1]}}};
      end else begin
        rot_d[r] = row[r][VW-1:0];
      end
    end
    clamped_d = |over;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o) begin
      rot_q     <= rot_d;
      clamped_q <= clamped_d;
    end
  end

  assign valid_o   = valid_q;
  assign rot_o     = rot_q;
  assign clamped_o = clamped_q;

endmodule

// File: rtl/core/quaternion_vector_rotate_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_top
// Rotates a signed 16-bit 3-vector by a Q1.14 quaternion, q * (v, 0) * q',
// with no normalisation; rounds half up, clamps to 16 bits and flags it.
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+-------------------------------------
//   input   | in_valid_i | in_stall_o  | quat_x/y/z/w_i, vec_x/y/z_i
//   output  | out_valid_o| out_stall_i | rot_x/y/z_o, clamped_o
//
// Four register stages (products, matrix, multiplies, sum and clamp), taking
// one transfer per cycle unless an output stall holds the stages.
// Reset clears the stage valid bits only.
// A stage holds while it is full and the stage after it stalls; empty stages
// keep filling, so bubbles close up under an output stall.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] quat_x_i,
  input  logic [15:0] quat_y_i,
  input  logic [15:0] quat_z_i,
  input  logic [15:0] quat_w_i,
  input  logic [15:0] vec_x_i,
  input  logic [15:0] vec_y_i,
  input  logic [15:0] vec_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] rot_x_o,
  output logic [15:0] rot_y_o,
  output logic [15:0] rot_z_o,
  output logic        clamped_o
);

  qvr_pkg::quat_t quat;
  qvr_pkg::vec_t  vec_in, vec_s1, vec_s2, rot;
  qvr_pkg::prod_t prod;
  qvr_pkg::mat_t  mat;
  qvr_pkg::term_t term;

  logic s1_valid, s2_valid, s3_valid;
  logic s2_stall, s3_stall, s4_stall;

  assign quat.x    = quat_x_i;
  assign quat.y    = quat_y_i;
  assign quat.z    = quat_z_i;
  assign quat.w    = quat_w_i;
  assign vec_in[0] = vec_x_i;
  assign vec_in[1] = vec_y_i;
  assign vec_in[2] = vec_z_i;

  qvr_prod u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .quat_i  (quat),
    .vec_i   (vec_in),
    .valid_o (s1_valid),
    .stall_i (s2_stall),
    .prod_o  (prod),
    .vec_o   (vec_s1)
  );

  qvr_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .stall_o (s2_stall),
    .prod_i  (prod),
    .vec_i   (vec_s1),
    .valid_o (s2_valid),
    .stall_i (s3_stall),
    .mat_o   (mat),
    .vec_o   (vec_s2)
  );

  qvr_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .stall_o (s3_stall),
    .mat_i   (mat),
    .vec_i   (vec_s2),
    .valid_o (s3_valid),
    .stall_i (s4_stall),
    .term_o  (term)
  );

  qvr_round u_round (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s3_valid),
    .stall_o   (s4_stall),
    .term_i    (term),
    .valid_o   (out_valid_o),
    .stall_i   (out_stall_i),
    .rot_o     (rot),
    .clamped_o (clamped_o)
  );

  assign rot_x_o = rot[0];
  assign rot_y_o = rot[1];
  assign rot_z_o = rot[2];

endmodule

// File: bench/quaternion_vector_rotate_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_top_tb
// Sends quaternion/vector pairs through the rotation pipeline and compares
// each output transfer with an exact integer rotation, rounded half up and
// clamped, held in arrival order. The sender runs in random bursts and the
// receiver stalls on a shifting random pattern.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_top_tb;

  localparam int MaxReports = 100;

  typedef struct {
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
  } rotation_req_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        clamped;
  } rotated_vec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] quat_x_i = '0;
  logic [15:0] quat_y_i = '0;
  logic [15:0] quat_z_i = '0;
  logic [15:0] quat_w_i = '0;
  logic [15:0] vec_x_i = '0;
  logic [15:0] vec_y_i = '0;
  logic [15:0] vec_z_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] rot_x_o;
  logic [15:0] rot_y_o;
  logic [15:0] rot_z_o;
  logic        clamped_o;

  rotated_vec_t rot_expected_q[$];
  rotated_vec_t oldest_rot;
  int           fail_count = 0;
  int           burst_left = 0;
  bit           sender_idles = 1'b1;
  bit           stall_enable = 1'b0;
  logic [15:0]  stall_pattern = '0;
  int           stall_phase = 0;

  quaternion_vector_rotate_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .quat_x_i   (quat_x_i),
    .quat_y_i   (quat_y_i),
    .quat_z_i   (quat_z_i),
    .quat_w_i   (quat_w_i),
    .vec_x_i    (vec_x_i),
    .vec_y_i    (vec_y_i),
    .vec_z_i    (vec_z_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .rot_x_o    (rot_x_o),
    .rot_y_o    (rot_y_o),
    .rot_z_o    (rot_z_o),
    .clamped_o  (clamped_o)
  );

  always #2 clk_i = ~clk_i;

  // q * (v, 0) * q' as the exact quadratic-form matrix times v
  function automatic rotated_vec_t predict_rotation(input rotation_req_t req);
    longint       qx, qy, qz, qw;
    longint       vin[3];
    longint       mat[3][3];
    longint       acc;
    longint       vmax;
    longint       vmin;
    logic [15:0]  comp[3];
    rotated_vec_t res;
    qx = longint'(req.qx);
    qy = longint'(req.qy);
    qz = longint'(req.qz);
    qw = longint'(req.qw);
    vin[0] = longint'(req.vx);
    vin[1] = longint'(req.vy);
    vin[2] = longint'(req.vz);
    vmax = (longint'(1) <<< (qvr_pkg::VecWidth - 1)) - 1;
    vmin = -vmax - 1;
    mat[0][0] = qw * qw + qx * qx - qy * qy - qz * qz;
    mat[0][1] = 2 * (qx * qy - qw * qz);
    mat[0][2] = 2 * (qx * qz + qw * qy);
    mat[1][0] = 2 * (qx * qy + qw * qz);
    mat[1][1] = qw * qw - qx * qx + qy * qy - qz * qz;
    mat[1][2] = 2 * (qy * qz - qw * qx);
    mat[2][0] = 2 * (qx * qz - qw * qy);
    mat[2][1] = 2 * (qy * qz + qw * qx);
    mat[2][2] = qw * qw - qx * qx - qy * qy + qz * qz;
    res.clamped = 1'b0;
    for (int row = 0; row < 3; row++) begin
      acc = mat[row][0] * vin[0] + mat[row][1] * vin[1] + mat[row][2] * vin[2];
      acc = (acc + (longint'(1) <<< (2 * qvr_pkg::QuatFracBits - 1)))
            >>> (2 * qvr_pkg::QuatFracBits);
      if (acc > vmax) begin
        acc = vmax;
        res.clamped = 1'b1;
      end else if (acc < vmin) begin
        acc = vmin;
        res.clamped = 1'b1;
      end
      comp[row] = acc[15:0];
    end
    res.x = comp[0];
    res.y = comp[1];
    res.z = comp[2];
    return res;
  endfunction

  function automatic rotation_req_t make_req(input int qx, input int qy, input int qz,
                                             input int qw, input int vx, input int vy,
                                             input int vz);
    rotation_req_t req;
    req.qx = 16'(qx);
    req.qy = 16'(qy);
    req.qz = 16'(qz);
    req.qw = 16'(qw);
    req.vx = 16'(vx);
    req.vy = 16'(vy);
    req.vz = 16'(vz);
    return req;
  endfunction

  function automatic logic [15:0] rand16();
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic int rand_signed16();
    return int'($signed(rand16()));
  endfunction

  function automatic rotation_req_t random_vec_req(input int qx, input int qy,
                                                   input int qz, input int qw);
    return make_req(qx, qy, qz, qw, rand_signed16(), rand_signed16(),
                    rand_signed16());
  endfunction

  task automatic send_rotation(input rotation_req_t req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (sender_idles) begin
        gap = $urandom_range(1, 6);
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    quat_x_i = req.qx;
    quat_y_i = req.qy;
    quat_z_i = req.qz;
    quat_w_i = req.qw;
    vec_x_i = req.vx;
    vec_y_i = req.vy;
    vec_z_i = req.vz;
    do @(posedge clk_i); while (in_stall_o);
    rot_expected_q.push_back(predict_rotation(req));
    burst_left--;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (rot_expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_cases();
    rotation_req_t cases[$];
    sender_idles = 1'b1;
    stall_enable = 1'b1;
    cases.push_back(make_req(0, 0, 0, 16384, 1, -2, 3));
    cases.push_back(make_req(0, 0, 0, 16384, 32767, -32768, 0));
    cases.push_back(make_req(0, 0, 0, -16384, -32768, 32767, -1));
    cases.push_back(make_req(0, 0, 0, 0, 32767, 32767, -32768));
    cases.push_back(make_req(0, 0, 11585, 11585, 10000, 0, 0));
    cases.push_back(make_req(0, 11585, 0, 11585, 0, 0, 20000));
    cases.push_back(make_req(16384, 0, 0, 0, -32768, 1234, -5));
    // half-way cases round up on both signs
    cases.push_back(make_req(0, 0, 0, 128, 8192, -8192, 24576));
    cases.push_back(make_req(0, 0, 0, 128, -24576, 40, -40));
    cases.push_back(make_req(0, 0, 0, 32767, 32767, 100, -32768));
    cases.push_back(make_req(0, 0, 0, -32768, -32768, 16384, -1));
    cases.push_back(make_req(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    cases.push_back(make_req(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    cases.push_back(make_req(-32768, 32767, -32768, 32767, 32767, -32768, 32767));
    cases.push_back(make_req(0, 0, 0, 1, 32767, -32768, 32767));
    cases.push_back(make_req(1, 1, 1, 1, -32768, -32768, -32768));
    cases.push_back(make_req(-1, -1, -1, -1, 0, 0, 0));
    cases.push_back(make_req(8192, -8192, 8192, -8192, 12345, -23456, 30000));
    foreach (cases[i]) send_rotation(cases[i]);
    drain_results();
  endtask

  task automatic test_unit_rotations(input int count);
    real comp[4];
    real norm;
    sender_idles = 1'b1;
    stall_enable = 1'b1;
    repeat (count) begin
      norm = 0.0;
      for (int k = 0; k < 4; k++) begin
        comp[k] = ($itor($urandom_range(0, 20000)) - 10000.0) / 10000.0;
        norm = norm + comp[k] * comp[k];
      end
      if (norm < 0.0001) begin
        comp[3] = 1.0;
        norm = 1.0;
      end
      norm = $sqrt(norm);
      send_rotation(random_vec_req($rtoi(comp[0] / norm * 16384.0),
                                   $rtoi(comp[1] / norm * 16384.0),
                                   $rtoi(comp[2] / norm * 16384.0),
                                   $rtoi(comp[3] / norm * 16384.0)));
    end
  endtask

  task automatic test_raw_fields(input int count);
    sender_idles = 1'b1;
    stall_enable = 1'b1;
    repeat (count) begin
      send_rotation(random_vec_req(rand_signed16(), rand_signed16(),
                                   rand_signed16(), rand_signed16()));
    end
  endtask

  task automatic test_scaled_quaternions(input int count);
    int span;
    sender_idles = 1'b1;
    stall_enable = 1'b1;
    repeat (count) begin
      span = 1 << $urandom_range(2, 13);
      send_rotation(random_vec_req($urandom_range(0, 2 * span) - span,
                                   $urandom_range(0, 2 * span) - span,
                                   $urandom_range(0, 2 * span) - span,
                                   $urandom_range(0, 2 * span) - span));
    end
  endtask

  task automatic test_streaming(input int count);
    // full rate first, then under output stalls
    sender_idles = 1'b0;
    stall_enable = 1'b0;
    test_raw_fields_quiet(count / 2);
    stall_enable = 1'b1;
    test_raw_fields_quiet(count - count / 2);
    sender_idles = 1'b1;
  endtask

  task automatic test_raw_fields_quiet(input int count);
    repeat (count) begin
      send_rotation(random_vec_req(rand_signed16(), rand_signed16(),
                                   rand_signed16(), rand_signed16()));
    end
  endtask

  // receiver stall pattern, reloaded at random intervals
  always @(negedge clk_i) begin
    if (stall_phase == 0) begin
      stall_phase = $urandom_range(20, 120);
      case ($urandom_range(0, 3))
        0: stall_pattern = '0;
        1: stall_pattern = rand16() & rand16();
        2: stall_pattern = rand16();
        default: stall_pattern = rand16() | rand16();
      endcase
    end
    stall_phase--;
    stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
    out_stall_i = stall_enable && stall_pattern[0];
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rot_expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports) $error("unexpected result transfer");
      end else begin
        oldest_rot = rot_expected_q.pop_front();
        if (rot_x_o !== oldest_rot.x) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $error("rot_x: expected %0d, actual %0d", $signed(oldest_rot.x),
                   $signed(rot_x_o));
        end
        if (rot_y_o !== oldest_rot.y) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $error("rot_y: expected %0d, actual %0d", $signed(oldest_rot.y),
                   $signed(rot_y_o));
        end
        if (rot_z_o !== oldest_rot.z) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $error("rot_z: expected %0d, actual %0d", $signed(oldest_rot.z),
                   $signed(rot_z_o));
        end
        if (clamped_o !== oldest_rot.clamped) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $error("clamped: expected %0b, actual %0b", oldest_rot.clamped, clamped_o);
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_cases();
    test_unit_rotations(220);
    drain_results();
    test_raw_fields(130);
    test_scaled_quaternions(120);
    test_streaming(130);
    drain_results();
    repeat (12) @(posedge clk_i);
    if (rot_expected_q.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

endmodule
